// ===== src/chip8_instruction_core_assert.svh =====
// ----------------------------------------------------------------------------
// chip8_instruction_core assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// same-cycle implication
`define C8IC_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("c8ic assertion failed");

// next-cycle implication
`define C8IC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("c8ic assertion failed");

`endif

// ===== src/c8ic_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ic_pkg
// Types, codes and helpers of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  localparam int MEM_AW     = 12;
  localparam int ROW_AW     = 5;
  localparam int ROW_W      = 64;
  localparam int PC_W       = 13;
  localparam int ROWS       = 32;
  localparam logic [PC_W-1:0] LOW_LIMIT = 13'd512;
  localparam logic [PC_W-1:0] HIGH_PC   = 13'd4095;
  localparam logic [11:0]     START_RST = 12'd512;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_ROW   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_WAIT  = 2'd1,
    ST_FAULT = 2'd2
  } status_t;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JP0  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] FN_SKP   = 8'h9E;
  localparam logic [7:0] FN_SKNP  = 8'hA1;
  localparam logic [7:0] FN_DLY   = 8'h07;
  localparam logic [7:0] FN_KEY   = 8'h0A;
  localparam logic [7:0] FN_ADDX  = 8'h1E;
  localparam logic [7:0] FN_FONT  = 8'h29;
  localparam logic [7:0] FN_BCD   = 8'h33;
  localparam logic [7:0] FN_STORE = 8'h55;
  localparam logic [7:0] FN_LOAD  = 8'h65;

  // {ones, tens, hundreds}
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [6:0] r;
    logic [6:0] o;
    h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
    r = (v >= 8'd200) ? 7'(v - 8'd200) : ((v >= 8'd100) ? 7'(v - 8'd100) : v[6:0]);
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(i * 10)) t = 4'(i);
    end
    o = 7'(r - 7'({t, 3'b000} + {2'b00, t, 1'b0}));
    return {o[3:0], t, h};
  endfunction

endpackage

// ===== src/c8ic_ram.sv =====
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core
// Memory commands: write goes to the result, reads via a read state. Step: fetch,
// read VX/VY, execute; fault/wait/key steps skip these. Draw (per row, plus VF),
// BCD, FX55/FX65 (per register), ALU flag ops and return add states. One command
// in flight; the single program-memory and register-file ports set the pace.
// Synchronous reset clears control, register and display valid bits at once.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_assert.svh"

module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[11:0] write_byte[19:12] keys_down[35:20] key_event[36]
  // key_event_code[40:37] random_byte[48:41] delay_value[56:49]
  input  logic [63:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // program_count[12:0] read_data[76:13]
  output logic [79:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser
);
  import c8ic_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MEMRD, S_FBRD, S_FETCH_HI, S_FETCH_LO, S_RDX, S_RDY, S_EXEC,
    S_FLAG, S_RET, S_DRAW_RD, S_DRAW_WR, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD,
    S_LD_WR, S_DONE
  } state_t;

  state_t           state_r;
  logic [11:0]      start_r;
  logic [PC_W-1:0]  pc_r;
  logic [15:0]      idx_r;
  logic [SDW-1:0]   sp_r;
  logic             fault_r;
  logic             wait_r;
  logic [3:0]       tgt_r;
  logic [15:0]      keys_r;
  logic [7:0]       rnd_r;
  logic [7:0]       dly_r;
  logic [7:0]       op_hi_r;
  logic [7:0]       op_lo_r;
  logic [7:0]       vx_r;
  logic [7:0]       vy_r;
  logic [3:0]       cnt_r;
  logic [ROW_AW-1:0] row_r;
  logic             hit_r;
  logic             flag_r;
  logic             fb_ok_r;
  logic [ROW_W-1:0] data_r;
  logic [15:0]      rf_vld_r;
  logic [ROWS-1:0]  fb_vld_r;
  logic             rf_rv_r;
  logic             fb_rv_r;
  logic             out_valid_r;
  logic [PC_W-1:0]  out_pc_r;
  logic [ROW_W-1:0] out_data_r;
  status_t          out_st_r;

  logic              pm_we;
  logic [MEM_AW-1:0] pm_waddr, pm_raddr;
  logic [7:0]        pm_wdata, pm_q;
  logic              rf_we;
  logic [3:0]        rf_waddr, rf_raddr;
  logic [7:0]        rf_wdata, rf_q;
  logic              fb_we;
  logic [ROW_AW-1:0] fb_waddr, fb_raddr;
  logic [ROW_W-1:0]  fb_wdata, fb_q;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [PC_W-1:0]   stk_wdata, stk_q;

  logic        acc;
  cmd_t        in_cmd;
  logic [11:0] in_addr;
  logic [15:0] op;
  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn;
  logic [7:0]  rv;
  logic [ROW_W-1:0] row_cur, sp_mask;
  logic [2*ROW_W-1:0] sp_dbl;
  logic [11:0] bcd;
  logic [MEM_AW-1:0] idx_addr;
  logic        pc_bad;
  logic        key_vx;
  logic        skip;
  logic [PC_W-1:0] pc_seq;
  logic        alu_we, alu_fl, alu_fv;
  logic [7:0]  alu_res;
  logic [8:0]  sum9;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_addr   = in_tdata[11:0];
  assign op        = {op_hi_r, op_lo_r};
  assign op_x      = op[11:8];
  assign op_y      = op[7:4];
  assign op_n      = op[3:0];
  assign op_nn     = op[7:0];
  assign op_nnn    = op[11:0];
  assign rv        = rf_q & {8{rf_rv_r}};
  assign row_cur   = fb_q & {ROW_W{fb_rv_r}};
  assign sp_dbl    = {pm_q, 56'd0, pm_q, 56'd0} >> vx_r[5:0];
  assign sp_mask   = sp_dbl[ROW_W-1:0];
  assign bcd       = bcd_digits(vx_r);
  assign idx_addr  = idx_r[MEM_AW-1:0] + {8'd0, cnt_r};
  assign pc_bad    = (pc_r < LOW_LIMIT) || (pc_r >= HIGH_PC);
  assign key_vx    = (vx_r[7:4] == 4'd0) && keys_r[vx_r[3:0]];
  assign sum9      = {1'b0, vx_r} + {1'b0, vy_r};

  always_comb begin
    skip = 1'b0;
    case (op[15:12])
      GRP_SEI:  skip = (vx_r == op_nn);
      GRP_SNEI: skip = (vx_r != op_nn);
      GRP_SER:  skip = (vx_r == vy_r);
      GRP_SNER: skip = (vx_r != vy_r);
      GRP_KEY:  skip = ((op_nn == FN_SKP) && key_vx) || ((op_nn == FN_SKNP) && !key_vx);
      default:  skip = 1'b0;
    endcase
    pc_seq = pc_r + (skip ? 13'd4 : 13'd2);
  end

  always_comb begin
    alu_we  = 1'b1;
    alu_fl  = 1'b0;
    alu_fv  = 1'b0;
    alu_res = vy_r;
    case (op_n)
      ALU_MOV: alu_res = vy_r;
      ALU_OR:  alu_res = vx_r | vy_r;
      ALU_AND: alu_res = vx_r & vy_r;
      ALU_XOR: alu_res = vx_r ^ vy_r;
      ALU_ADD: begin
        alu_res = sum9[7:0];
        alu_fl  = 1'b1;
        alu_fv  = sum9[8];
      end
      ALU_SUB: begin
        alu_res = vx_r - vy_r;
        alu_fl  = 1'b1;
        alu_fv  = (vx_r >= vy_r);
      end
      ALU_SHR: begin
        alu_res = {1'b0, vx_r[7:1]};
        alu_fl  = 1'b1;
        alu_fv  = vx_r[0];
      end
      ALU_SBN: begin
        alu_res = vy_r - vx_r;
        alu_fl  = 1'b1;
        alu_fv  = (vy_r >= vx_r);
      end
      ALU_SHL: begin
        alu_res = {vx_r[6:0], 1'b0};
        alu_fl  = 1'b1;
        alu_fv  = vx_r[7];
      end
      default: alu_we = 1'b0;
    endcase
  end

  // memory port steering
  always_comb begin
    pm_we     = 1'b0;
    pm_waddr  = idx_addr;
    pm_wdata  = rv;
    pm_raddr  = idx_addr;
    rf_we     = 1'b0;
    rf_waddr  = op_x;
    rf_wdata  = alu_res;
    rf_raddr  = cnt_r;
    fb_we     = 1'b0;
    fb_waddr  = row_r;
    fb_wdata  = row_cur ^ sp_mask;
    fb_raddr  = vy_r[ROW_AW-1:0] + {1'b0, cnt_r};
    stk_we    = 1'b0;
    stk_waddr = sp_r[SAW-1:0];
    stk_wdata = pc_r;
    stk_raddr = SAW'(sp_r - SDW'(1));
    unique case (state_r)
      S_IDLE: begin
        pm_raddr = (in_cmd == CMD_STEP) ? pc_r[MEM_AW-1:0] : in_addr;
        fb_raddr = in_addr[ROW_AW-1:0];
        pm_waddr = in_addr;
        pm_wdata = in_tdata[19:12];
        pm_we    = acc && (in_cmd == CMD_WRITE);
        rf_waddr = tgt_r;
        rf_wdata = {4'd0, in_tdata[40:37]};
        rf_we    = acc && (in_cmd == CMD_STEP) && !fault_r && !pc_bad && wait_r
                   && in_tdata[36];
      end
      S_FETCH_HI: pm_raddr = pc_r[MEM_AW-1:0] + 12'd1;
      S_FETCH_LO: rf_raddr = op_hi_r[3:0];
      S_RDX:      rf_raddr = (op_hi_r[7:4] == GRP_JP0) ? 4'd0 : op_lo_r[7:4];
      S_EXEC: begin
        case (op[15:12])
          GRP_LDI: begin
            rf_we    = 1'b1;
            rf_wdata = op_nn;
          end
          GRP_ADDI: begin
            rf_we    = 1'b1;
            rf_wdata = vx_r + op_nn;
          end
          GRP_ALU: rf_we = alu_we;
          GRP_RND: begin
            rf_we    = 1'b1;
            rf_wdata = rnd_r & op_nn;
          end
          GRP_CALL: stk_we = (sp_r != SDW'(STACK_DEPTH));
          default: begin
            rf_we    = (op[15:12] == GRP_MISC) && (op_nn == FN_DLY);
            rf_wdata = dly_r;
          end
        endcase
      end
      S_FLAG: begin
        rf_we    = 1'b1;
        rf_waddr = 4'hF;
        rf_wdata = {7'd0, flag_r};
      end
      S_DRAW_WR: fb_we = 1'b1;
      S_BCD: begin
        pm_we = 1'b1;
        case (cnt_r[1:0])
          2'd0:    pm_wdata = {4'd0, bcd[3:0]};
          2'd1:    pm_wdata = {4'd0, bcd[7:4]};
          default: pm_wdata = {4'd0, bcd[11:8]};
        endcase
      end
      S_ST_WR: pm_we = 1'b1;
      S_LD_WR: begin
        rf_we    = 1'b1;
        rf_waddr = cnt_r;
        rf_wdata = pm_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= START_RST;
      pc_r        <= {1'b0, START_RST};
      idx_r       <= '0;
      sp_r        <= '0;
      fault_r     <= 1'b0;
      wait_r      <= 1'b0;
      tgt_r       <= '0;
      rf_vld_r    <= '0;
      fb_vld_r    <= '0;
      rf_rv_r     <= 1'b0;
      fb_rv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rf_rv_r <= rf_vld_r[rf_raddr];
      fb_rv_r <= fb_vld_r[fb_raddr];
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
      if (fb_we) fb_vld_r[fb_waddr] <= 1'b1;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            keys_r <= in_tdata[35:20];
            rnd_r  <= in_tdata[48:41];
            dly_r  <= in_tdata[56:49];
            data_r <= '0;
            fb_ok_r <= (in_addr < 12'(ROWS));
            unique case (in_cmd)
              CMD_WRITE: state_r <= S_DONE;
              CMD_READ:  state_r <= S_MEMRD;
              CMD_ROW:   state_r <= S_FBRD;
              CMD_STEP: begin
                if (fault_r) begin
                  state_r <= S_DONE;
                end else if (pc_bad) begin
                  fault_r <= 1'b1;
                  state_r <= S_DONE;
                end else if (wait_r) begin
                  if (in_tdata[36]) wait_r <= 1'b0;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_FETCH_HI;
                end
              end
            endcase
          end
        end
        S_MEMRD: begin
          data_r  <= {56'd0, pm_q};
          state_r <= S_DONE;
        end
        S_FBRD: begin
          data_r  <= fb_ok_r ? row_cur : '0;
          state_r <= S_DONE;
        end
        S_FETCH_HI: begin
          op_hi_r <= pm_q;
          state_r <= S_FETCH_LO;
        end
        S_FETCH_LO: begin
          op_lo_r <= pm_q;
          state_r <= S_RDX;
        end
        S_RDX: begin
          vx_r    <= rv;
          state_r <= S_RDY;
        end
        S_RDY: begin
          vy_r    <= rv;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          cnt_r   <= '0;
          hit_r   <= 1'b0;
          pc_r    <= pc_seq;
          state_r <= S_DONE;
          case (op[15:12])
            GRP_SYS: begin
              if (op == OP_CLS) begin
                fb_vld_r <= '0;
              end else if (op == OP_RET) begin
                pc_r <= pc_r;
                if (sp_r == '0) begin
                  fault_r <= 1'b1;
                end else begin
                  sp_r    <= sp_r - SDW'(1);
                  state_r <= S_RET;
                end
              end
            end
            GRP_JP: pc_r <= {1'b0, op_nnn};
            GRP_CALL: begin
              if (sp_r == SDW'(STACK_DEPTH)) begin
                fault_r <= 1'b1;
                pc_r    <= pc_r;
              end else begin
                sp_r <= sp_r + SDW'(1);
                pc_r <= {1'b0, op_nnn};
              end
            end
            GRP_ALU: begin
              flag_r <= alu_fv;
              if (alu_fl) state_r <= S_FLAG;
            end
            GRP_LDIX: idx_r <= {4'd0, op_nnn};
            GRP_JP0:  pc_r <= {1'b0, op_nnn} + {5'd0, vy_r};
            GRP_DRW: begin
              flag_r  <= 1'b0;
              state_r <= (op_n == 4'd0) ? S_FLAG : S_DRAW_RD;
            end
            GRP_MISC: begin
              case (op_nn)
                FN_KEY: begin
                  wait_r <= 1'b1;
                  tgt_r  <= op_x;
                end
                FN_ADDX:  idx_r <= idx_r + {8'd0, vx_r};
                FN_FONT:  idx_r <= {6'd0, vx_r, 2'd0} + {8'd0, vx_r};
                FN_BCD:   state_r <= S_BCD;
                FN_STORE: state_r <= S_ST_RD;
                FN_LOAD:  state_r <= S_LD_RD;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_FLAG: state_r <= S_DONE;
        S_RET: begin
          pc_r    <= stk_q + 13'd2;
          state_r <= S_DONE;
        end
        S_DRAW_RD: begin
          row_r   <= fb_raddr;
          state_r <= S_DRAW_WR;
        end
        S_DRAW_WR: begin
          hit_r <= hit_r | (|(row_cur & sp_mask));
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == op_n - 4'd1) begin
            flag_r  <= hit_r | (|(row_cur & sp_mask));
            state_r <= S_FLAG;
          end else begin
            state_r <= S_DRAW_RD;
          end
        end
        S_BCD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd2) state_r <= S_DONE;
        end
        S_ST_RD: state_r <= S_ST_WR;
        S_ST_WR: begin
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == op_x) ? S_DONE : S_ST_RD;
        end
        S_LD_RD: state_r <= S_LD_WR;
        S_LD_WR: begin
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == op_x) ? S_DONE : S_LD_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= pc_r;
            out_data_r  <= data_r;
            out_st_r    <= fault_r ? ST_FAULT : (wait_r ? ST_WAIT : ST_RUN);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_we) begin
        start_r <= cfg_wdata;
        pc_r    <= {1'b0, cfg_wdata};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r, out_pc_r};
  assign out_tuser  = out_st_r;

  c8ic_ram #(.WIDTH(8), .DEPTH(1 << MEM_AW)) u_pmem (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_q)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_q)
  );

  c8ic_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_q)
  );

  c8ic_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  `C8IC_ASSERT_NXT(a_accept_leaves_idle, acc, state_r != S_IDLE)
  `C8IC_ASSERT_NXT(a_fault_sticky, fault_r && !cfg_we, fault_r)
  `C8IC_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= SDW'(STACK_DEPTH))
  `C8IC_ASSERT_NXT(a_done_delivers, state_r == S_DONE && !out_valid_r, out_valid_r)

endmodule
